/* rtl/core/b3dcp_pkg.sv */
// Shared types, constants and helpers for the 3D box corner projection block.
package b3dcp_pkg;

	// Fixed-point constants of the sine/cosine unit, all Q2.30.
	localparam int CORDIC_ITERS = 30;
	localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;
	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_COEF_01 = 3'd0,
		REG_COEF_23 = 3'd1,
		REG_COEF_45 = 3'd2,
		REG_COEF_67 = 3'd3,
		REG_COEF_89 = 3'd4,
		REG_COEF_AB = 3'd5
	} reg_idx_t;

	// One box as it travels down the sine/cosine pipeline.
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic        [30:0] len;
		logic        [30:0] hgt;
		logic        [30:0] wid;
	} box_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		logic signed [35:0] t;
		unique case (i)
			5'd0: t = 36'sd843314857;
			5'd1: t = 36'sd497837829;
			5'd2: t = 36'sd263043837;
			5'd3: t = 36'sd133525159;
			5'd4: t = 36'sd67021687;
			5'd5: t = 36'sd33543516;
			5'd6: t = 36'sd16775851;
			5'd7: t = 36'sd8388437;
			5'd8: t = 36'sd4194283;
			5'd9: t = 36'sd2097149;
			default: t = 36'sd1 <<< (6'd30 - {1'b0, i});
		endcase
		return t;
	endfunction

	// Unit-cube corner visited at output position k: 0,1,3,2,4,5,7,6.
	function automatic logic [2:0] corner_seq(input logic [2:0] k);
		return {k[2], k[1], k[0] ^ k[1]};
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

/* rtl/core/b3dcp_cordic.sv */
// Pipelined CORDIC: one rotation per stage, producing cos and sin of the yaw in Q2.30.
module b3dcp_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [15:0]   yaw,
	input  b3dcp_pkg::box_t      box_in,
	output logic                 out_valid,
	output logic signed [35:0]   cos_q,
	output logic signed [35:0]   sin_q,
	output b3dcp_pkg::box_t      box_out
);
	import b3dcp_pkg::*;

	localparam int N = CORDIC_ITERS;

	logic               vld_s [N+1];
	logic signed [35:0] x_s   [N+1];
	logic signed [35:0] y_s   [N+1];
	logic signed [35:0] a_s   [N+1];
	logic               neg_s [N+1];
	box_t               box_s [N+1];

	// Range reduction of the angle into plus or minus half pi.
	logic signed [35:0] a0;
	always_comb begin
		a0 = {{3{yaw[15]}}, yaw, 17'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= CORDIC_K;
			y_s[0]   <= '0;
			box_s[0] <= box_in;
			if (a0 > Q30_HALF_PI) begin
				a_s[0] <= a0 - Q30_PI;
				neg_s[0] <= 1'b1;
			end else if (a0 < -Q30_HALF_PI) begin
				a_s[0] <= a0 + Q30_PI;
				neg_s[0] <= 1'b1;
			end else begin
				a_s[0] <= a0;
				neg_s[0] <= 1'b0;
			end
		end
	end

	// One rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				box_s[i+1] <= box_s[i];
				if (!a_s[i][35]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_q30(5'(i));
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign cos_q     = neg_s[N] ? -x_s[N] : x_s[N];
	assign sin_q     = neg_s[N] ? -y_s[N] : y_s[N];
	assign box_out   = box_s[N];
endmodule

/* rtl/core/b3dcp_divider.sv */
// Pipelined restoring divider giving a saturated signed Q quotient, one bit per stage.
module b3dcp_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [95:0]   num,
	input  logic signed [95:0]   den,
	output logic                 out_valid,
	output logic signed [31:0]   quo
);
	// The integer part must stay below 2^(32-FRAC_BITS), so that many high bits plus
	// FRAC_BITS fraction bits are resolved: 32 quotient bits in total.
	localparam int QB = 32;
	localparam int W  = 96;

	logic          vld_s [QB+1];
	logic [W-1:0]  d_s   [QB+1];
	logic [W+QB-1:0] r_s [QB+1];
	logic [QB:0]   q_s   [QB+1];
	logic          ng_s  [QB+1];
	logic          dz_s  [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_valid;
	end

	// Take magnitudes; numerator scaled by 2^FRAC_BITS sits in the remainder register.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0]  <= den[W-1] ? W'(-den) : W'(den);
			r_s[0]  <= (W+QB)'(num[W-1] ? W'(-num) : W'(num)) << FRAC_BITS;
			q_s[0]  <= '0;
			ng_s[0] <= num[W-1] ^ den[W-1];
			dz_s[0] <= 1'b0;
		end
	end

	// Bit i of the stage chain tests quotient bit QB-1-i.
	for (genvar i = 0; i < QB; i++) begin : g_bit
		localparam int SH = QB - 1 - i;
		logic [W+QB-1:0] dsh;
		logic            hi;
		assign hi  = (SH > 0) ? |(d_s[i] >> (W - SH)) : 1'b0;
		assign dsh = (W+QB)'(d_s[i]) << SH;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else if (en) vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1]  <= d_s[i];
				ng_s[i+1] <= ng_s[i];
				if (!hi && r_s[i] >= dsh) begin
					r_s[i+1] <= r_s[i] - dsh;
					q_s[i+1] <= q_s[i] | ((QB+1)'(1) << SH);
				end else begin
					r_s[i+1] <= r_s[i];
					q_s[i+1] <= q_s[i];
				end
				// A remainder of at least twice the shifted divisor at the top check means the integer part overflows.
				dz_s[i+1] <= dz_s[i] | ((i == 0) && (r_s[i] >= (dsh << 1)));
			end
		end
	end

	// Sign and saturation.
	always_comb begin
		logic [QB:0] q;
		q = q_s[QB];
		if (ng_s[QB]) begin
			if (dz_s[QB] || q > (QB+1)'(33'h080000000)) quo = 32'sh80000000;
			else quo = 32'(-$signed({1'b0, q}));
		end else begin
			if (dz_s[QB] || q > (QB+1)'(33'h07FFFFFFF)) quo = 32'sh7FFFFFFF;
			else quo = q[31:0];
		end
	end
	assign out_valid = vld_s[QB];
endmodule

/* rtl/core/box3d_corner_projection.sv */
// Top level: box intake, corner sequencing, rotation, projection and divide pipeline.
//
// Channel | Dir | Word
// s_axis  | in  | one box: tdata = center_x,center_y,center_z,box_length,box_height,
//         |     |   box_width,yaw_angle (lowest first)
// m_axis  | out | one corner: tdata = corner_index,cam_x,cam_y,cam_z,img_u,img_v;
//         |     |   tuser = depth_zero; tlast = last_corner
// cfg     | in  | matrix coefficient writes, index 0..5
//
// A new box is taken only once the gap counter has run down; one corner leaves per cycle
// while m_axis_tready does not stall the output. A corner passes 31 CORDIC stages, the
// sequencer, four corner stages, 33 divider stages and the output register.
// Reset clears all valid bits and the matrix; payload registers are not reset.
// The whole pipeline advances together; it halts while a result waits on m_axis_tready.
module box3d_corner_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [207:0]  s_axis_tdata,   // cx, cy, cz, len, hgt, wid, yaw, pad
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [167:0]  m_axis_tdata,   // corner_index, cam_x, cam_y, cam_z, img_u, img_v, pad
	output logic          m_axis_tuser,   // depth_zero
	output logic          m_axis_tlast,   // last_corner
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [63:0]   cfg_data
);
	import b3dcp_pkg::*;

	// Matrix coefficients.
	logic signed [31:0] p_q [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 12; i++) p_q[i] <= '0;
		end else if (cfg_we && cfg_idx <= REG_COEF_AB) begin
			p_q[{cfg_idx, 1'b0}] <= cfg_data[31:0];
			p_q[{cfg_idx, 1'b1}] <= cfg_data[63:32];
		end
	end

	// Pipeline advance: a full output register holds everything.
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || m_axis_tready;

	// Intake: a gap counter spaces the boxes so the sequencer has finished one before the next.
	logic [2:0] gap_q;
	assign s_axis_tready = en && (gap_q == 3'd0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= '0;
		else if (s_axis_tvalid && s_axis_tready) gap_q <= 3'd7;
		else if (en && gap_q != 3'd0) gap_q <= gap_q - 3'd1;
	end

	box_t in_box;
	always_comb begin
		in_box.cx  = s_axis_tdata[31:0];
		in_box.cy  = s_axis_tdata[63:32];
		in_box.cz  = s_axis_tdata[95:64];
		in_box.len = s_axis_tdata[126:96];
		in_box.hgt = s_axis_tdata[157:127];
		in_box.wid = s_axis_tdata[188:158];
	end

	logic               cv;
	logic signed [35:0] cs, sn;
	box_t               cb;
	b3dcp_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid && s_axis_tready),
		.yaw(s_axis_tdata[204:189]), .box_in(in_box),
		.out_valid(cv), .cos_q(cs), .sin_q(sn), .box_out(cb)
	);

	// Corner sequencer: hold the box and step through eight positions.
	logic               seq_act_q;
	logic [2:0]         k_q;
	logic signed [35:0] cs_q, sn_q;
	box_t               box_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_act_q <= 1'b0;
			k_q <= '0;
		end else if (en) begin
			if (cv) begin
				seq_act_q <= 1'b1;
				k_q <= '0;
			end else if (seq_act_q) begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd7) seq_act_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en && cv) begin
			cs_q <= cs;
			sn_q <= sn;
			box_q <= cb;
		end
	end

	// Stage 1: four products of signed extents by cos and sin.
	logic               v_s1;
	logic [2:0]         k_s1;
	logic signed [67:0] lc_s1, ls_s1, zc_s1, zs_s1;
	logic signed [32:0] cy_s1;
	logic signed [31:0] cx_s1, cz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= seq_act_q;
	end
	always_ff @(posedge clk) begin
		logic [2:0] c;
		logic signed [31:0] lx, lz;
		if (en) begin
			c  = corner_seq(k_q);
			lx = c[0] ? $signed({1'b0, box_q.len}) : -$signed({1'b0, box_q.len});
			lz = c[2] ? $signed({1'b0, box_q.wid}) : -$signed({1'b0, box_q.wid});
			k_s1  <= k_q;
			lc_s1 <= lx * cs_q;
			ls_s1 <= lx * sn_q;
			zc_s1 <= lz * cs_q;
			zs_s1 <= lz * sn_q;
			cy_s1 <= c[1] ? 33'(box_q.cy) : 33'(box_q.cy) - $signed({2'b0, box_q.hgt});
			cx_s1 <= box_q.cx;
			cz_s1 <= box_q.cz;
		end
	end

	// Stage 2: rotate, round, translate, saturate.
	logic               v_s2;
	logic [2:0]         k_s2;
	logic signed [31:0] x_s2, y_s2, z_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		logic signed [68:0] rx, rz;
		if (en) begin
			rx = (69'(lc_s1) - 69'(zs_s1) + (69'sd1 <<< 30)) >>> 31;
			rz = (69'(ls_s1) + 69'(zc_s1) + (69'sd1 <<< 30)) >>> 31;
			k_s2 <= k_s1;
			x_s2 <= sat32(64'(cx_s1) + 64'(rx));
			y_s2 <= sat32(64'(cy_s1));
			z_s2 <= sat32(64'(cz_s1) + 64'(rz));
		end
	end

	// Stage 3: nine matrix products, each taken at full width and floor-shifted by two.
	logic               v_s3;
	logic [2:0]         k_s3;
	logic signed [31:0] x_s3, y_s3, z_s3;
	logic signed [61:0] m_s3 [9];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_s3 <= k_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
			for (int r = 0; r < 3; r++) begin
				m_s3[r*3]   <= 62'((64'(p_q[r*4])   * 64'(x_s2)) >>> 2);
				m_s3[r*3+1] <= 62'((64'(p_q[r*4+1]) * 64'(y_s2)) >>> 2);
				m_s3[r*3+2] <= 62'((64'(p_q[r*4+2]) * 64'(z_s2)) >>> 2);
			end
		end
	end

	// Stage 4: row sums with the translation column.
	logic               v_s4;
	logic [2:0]         k_s4;
	logic signed [31:0] x_s4, y_s4, z_s4;
	logic signed [95:0] px_s4, py_s4, pz_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_s4 <= k_s3;
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			z_s4 <= z_s3;
			px_s4 <= 96'(m_s3[0]) + 96'(m_s3[1]) + 96'(m_s3[2])
			       + (96'(p_q[3]) <<< (FRAC_BITS - 2));
			py_s4 <= 96'(m_s3[3]) + 96'(m_s3[4]) + 96'(m_s3[5])
			       + (96'(p_q[7]) <<< (FRAC_BITS - 2));
			pz_s4 <= 96'(m_s3[6]) + 96'(m_s3[7]) + 96'(m_s3[8])
			       + (96'(p_q[11]) <<< (FRAC_BITS - 2));
		end
	end

	// Dividers for u and v; side data rides a delay line of equal length.
	localparam int DL = 33;
	logic               dv_u, dv_v;
	logic signed [31:0] qu, qv;
	b3dcp_divider #(.FRAC_BITS(FRAC_BITS)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(px_s4), .den(pz_s4), .out_valid(dv_u), .quo(qu)
	);
	b3dcp_divider #(.FRAC_BITS(FRAC_BITS)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num(py_s4), .den(pz_s4), .out_valid(dv_v), .quo(qv)
	);

	typedef struct packed {
		logic [2:0]  k;
		logic [31:0] x, y, z;
		logic        dz, su, sv;
	} side_t;
	side_t side_d [DL+1];
	always_comb begin
		side_d[0].k  = k_s4;
		side_d[0].x  = x_s4;
		side_d[0].y  = y_s4;
		side_d[0].z  = z_s4;
		side_d[0].dz = (pz_s4 == '0);
		side_d[0].su = px_s4[95];
		side_d[0].sv = py_s4[95];
	end
	for (genvar i = 0; i < DL; i++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) side_d[i+1] <= side_d[i];
		end
	end

	// Output register.
	logic [167:0] od_q;
	logic         ou_q, ol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_u && dv_v;
	end
	always_ff @(posedge clk) begin
		side_t sd;
		logic [31:0] u, v;
		if (en) begin
			sd = side_d[DL];
			u = sd.dz ? (sd.su ? 32'h80000000 : 32'h7FFFFFFF) : qu;
			v = sd.dz ? (sd.sv ? 32'h80000000 : 32'h7FFFFFFF) : qv;
			od_q <= {5'd0, v, u, sd.z, sd.y, sd.x, sd.k};
			ou_q <= sd.dz;
			ol_q <= (sd.k == 3'd7);
		end
	end
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tuser  = ou_q;
	assign m_axis_tlast  = ol_q;

	// The sequencer never sees a new box while still stepping an old one.
	a_seq_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(en && cv) |-> (!seq_act_q || k_q == 3'd7))
		else $error("box arrived mid sequence");
	// Both dividers stay in lockstep.
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n) dv_u == dv_v)
		else $error("dividers out of step");
	// Last flag marks only the eighth corner.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd7)))
		else $error("last flag misplaced");
endmodule
